### src/power_up_down_sequencer_core_defines.svh
// Assertion macros shared by the power sequencer RTL.
// Relies on clk and rst being in scope where a macro is used.
`ifndef POWER_UP_DOWN_SEQUENCER_CORE_DEFINES_SVH
`define POWER_UP_DOWN_SEQUENCER_CORE_DEFINES_SVH

// Checked on every clock edge, masked while reset is applied.
`define PUSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PUSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pusq_pkg.sv
// Types and constants for the power up/down sequencer.
// Used by pusq_step and power_up_down_sequencer_core; no dependencies.
package pusq_pkg;

  typedef enum logic [3:0] {
    ST_ON_START     = 4'd0,
    ST_ON_DELAY     = 4'd1,
    ST_HOST_RESET   = 4'd2,
    ST_RECOVER      = 4'd3,
    ST_DISP_ON      = 4'd4,
    ST_SECURITY     = 4'd5,
    ST_RUN          = 4'd6,
    ST_CLOSE_SCREEN = 4'd7,
    ST_OFF_DELAY    = 4'd8,
    ST_STANDBY      = 4'd9,
    ST_ACCOFF       = 4'd10,
    ST_ACCOFF2      = 4'd11,
    ST_ERR_RESET    = 4'd12
  } seq_state_t;

  // Message kinds
  localparam logic [1:0] MSG_NONE = 2'd0;
  localparam logic [1:0] MSG_ON   = 2'd1;
  localparam logic [1:0] MSG_OFF  = 2'd2;

  // Off reasons
  localparam logic [1:0] RSN_ON    = 2'd0;
  localparam logic [1:0] RSN_IGN   = 2'd1;
  localparam logic [1:0] RSN_VOLT  = 2'd2;
  localparam logic [1:0] RSN_OTHER = 2'd3;

  // Event pulse bit positions
  localparam int EV_APP_OK = 0;
  localparam int EV_SLEEP  = 1;
  localparam int EV_VOLUME = 2;
  localparam int EV_48K    = 3;

  // Register indexes (byte address bits [4:2])
  localparam int          REG_IDX_W            = 3;
  localparam int          ADDR_W               = 5;
  localparam logic [2:0]  REG_START_WAIT       = 3'd0;
  localparam logic [2:0]  REG_RESET_WAIT       = 3'd1;
  localparam logic [2:0]  REG_RECOVER_WAIT     = 3'd2;
  localparam logic [2:0]  REG_DSP_TIMEOUT      = 3'd3;
  localparam logic [2:0]  REG_CLOSE_WAIT       = 3'd4;
  localparam logic [2:0]  REG_REMOTE_OFF_WAIT  = 3'd5;
  localparam logic [2:0]  REG_ACCOFF_WAIT      = 3'd6;
  localparam logic [2:0]  REG_OPAMP_OFF_WAIT   = 3'd7;

  typedef struct packed {
    logic [15:0] start_wait;
    logic [15:0] reset_wait;
    logic [15:0] recover_wait;
    logic [15:0] dsp_timeout;
    logic [15:0] close_screen_wait;
    logic [15:0] remote_off_wait;
    logic [15:0] accoff_wait;
    logic [15:0] opamp_off_wait;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    start_wait:        16'd50,
    reset_wait:        16'd12,
    recover_wait:      16'd60,
    dsp_timeout:       16'd500,
    close_screen_wait: 16'd3,
    remote_off_wait:   16'd375,
    accoff_wait:       16'd625,
    opamp_off_wait:    16'd30
  };

  typedef struct packed {
    logic [1:0] msg_kind;
    logic [1:0] msg_reason;
    logic       ignition_on;
    logic       voltage_error;
    logic       sleep_active;
    logic       dsp_ready;
  } item_t;

  typedef struct packed {
    logic mute;
    logic main_pwr;
    logic remote;
    logic usb;
    logic opamp;
    logic amp;
    logic host_rst;
    logic periph_rst;
  } lvl_t;

  typedef struct packed {
    seq_state_t  seq;
    logic [15:0] timer;
    logic [1:0]  reason;
    logic        pending_on;
    logic        app_started;
    lvl_t        lv;
  } core_state_t;

  localparam core_state_t CORE_RESET = '{
    seq:         ST_ON_START,
    timer:       16'd0,
    reason:      RSN_ON,
    pending_on:  1'b0,
    app_started: 1'b0,
    lv:          '{mute: 1'b1, default: 1'b0}
  };

  typedef struct packed {
    seq_state_t seq;
    logic [1:0] reason;
    lvl_t       lv;
    logic       dsp_pulse;
    logic [3:0] events;
  } result_t;

endpackage

### src/pusq_step.sv
// One sequencer tick: message handling, timer advance and state step.
// Pure combinational; depends on pusq_pkg.
module pusq_step #(
  parameter int ERR_RESET_TICKS = 125
) (
  input  pusq_pkg::core_state_t st,
  input  pusq_pkg::item_t       item,
  input  pusq_pkg::cfg_t        cfg,
  output pusq_pkg::core_state_t st_next,
  output pusq_pkg::result_t     res
);

  localparam logic [15:0] ErrTicks = 16'(ERR_RESET_TICKS);

  pusq_pkg::core_state_t n;
  logic                  dsp_pulse;
  logic [3:0]            events;

  function automatic pusq_pkg::core_state_t power_off_all(pusq_pkg::core_state_t s);
    pusq_pkg::core_state_t r;
    r               = s;
    r.lv.mute       = 1'b1;
    r.lv.amp        = 1'b0;
    r.lv.main_pwr   = 1'b0;
    r.lv.periph_rst = 1'b1;
    r.lv.host_rst   = 1'b1;
    r.lv.usb        = 1'b0;
    r.app_started   = 1'b0;
    return r;
  endfunction

  always_comb begin
    n         = st;
    dsp_pulse = 1'b0;
    events    = '0;

    // message phase: a self-posted power-on wins over the external message
    if (st.pending_on || item.msg_kind == pusq_pkg::MSG_ON) begin
      n.pending_on = 1'b0;
      n.reason     = pusq_pkg::RSN_ON;
      n.seq        = pusq_pkg::ST_ON_DELAY;
      n.timer      = '0;
      n.lv.mute    = 1'b1;
    end else if (item.msg_kind == pusq_pkg::MSG_OFF) begin
      n.reason = item.msg_reason;
      if (item.msg_reason inside {pusq_pkg::RSN_IGN, pusq_pkg::RSN_VOLT}) begin
        if (st.seq < pusq_pkg::ST_CLOSE_SCREEN) begin
          if (item.msg_reason == pusq_pkg::RSN_IGN) begin
            n.seq                        = pusq_pkg::ST_ACCOFF;
            events[pusq_pkg::EV_VOLUME]  = 1'b1;
          end else begin
            n.seq = pusq_pkg::ST_CLOSE_SCREEN;
          end
          n.timer = '0;
        end
      end else begin
        n.timer = '0;
      end
    end

    // saturating tick count
    if (n.timer != 16'hFFFF) begin
      n.timer = n.timer + 16'd1;
    end

    case (n.seq)
      pusq_pkg::ST_ON_START: begin
        if (n.timer >= cfg.start_wait) begin
          if (item.ignition_on && !item.voltage_error) begin
            n.pending_on = 1'b1;
          end else begin
            if (item.voltage_error) begin
              n.reason = pusq_pkg::RSN_VOLT;
            end
            n.seq   = pusq_pkg::ST_OFF_DELAY;
            n.timer = '0;
          end
        end
      end
      pusq_pkg::ST_ON_DELAY: begin
        n.seq           = pusq_pkg::ST_HOST_RESET;
        n.timer         = '0;
        n.lv.mute       = 1'b1;
        n.lv.host_rst   = 1'b1;
        n.lv.periph_rst = 1'b1;
        n.lv.main_pwr   = 1'b1;
        n.lv.remote     = 1'b1;
        n.lv.usb        = 1'b1;
        n.lv.opamp      = 1'b1;
      end
      pusq_pkg::ST_HOST_RESET: begin
        if (n.timer >= cfg.reset_wait) begin
          n.lv.periph_rst = 1'b1;
          n.seq           = pusq_pkg::ST_RECOVER;
          n.timer         = '0;
        end
      end
      pusq_pkg::ST_RECOVER: begin
        if (n.timer >= cfg.recover_wait) begin
          n.timer         = '0;
          n.seq           = pusq_pkg::ST_DISP_ON;
          n.lv.amp        = 1'b1;
          n.lv.host_rst   = 1'b0;
          n.lv.periph_rst = 1'b0;
        end
      end
      pusq_pkg::ST_DISP_ON: begin
        if (n.timer >= cfg.reset_wait) begin
          n.timer   = '0;
          dsp_pulse = 1'b1;
          n.reason  = pusq_pkg::RSN_ON;
          n.seq     = pusq_pkg::ST_SECURITY;
        end
      end
      pusq_pkg::ST_SECURITY: begin
        if (item.dsp_ready || n.timer >= cfg.dsp_timeout) begin
          n.lv.mute                   = 1'b0;
          n.app_started               = 1'b1;
          events[pusq_pkg::EV_APP_OK] = 1'b1;
          events[pusq_pkg::EV_48K]    = 1'b1;
          n.seq                       = pusq_pkg::ST_RUN;
        end
      end
      pusq_pkg::ST_CLOSE_SCREEN: begin
        if (n.timer >= cfg.close_screen_wait) begin
          n       = power_off_all(n);
          n.timer = '0;
          n.seq   = pusq_pkg::ST_OFF_DELAY;
        end
      end
      pusq_pkg::ST_OFF_DELAY: begin
        n.seq = item.ignition_on ? pusq_pkg::ST_STANDBY : pusq_pkg::ST_ACCOFF;
      end
      pusq_pkg::ST_STANDBY: begin
        if (!item.sleep_active && !item.voltage_error) begin
          if (item.ignition_on) begin
            n.pending_on = 1'b1;
          end else begin
            n.seq = pusq_pkg::ST_ACCOFF;
          end
        end
      end
      pusq_pkg::ST_ACCOFF: begin
        if (n.timer >= cfg.remote_off_wait) begin
          n.lv.remote = 1'b0;
        end
        if (n.timer >= cfg.accoff_wait) begin
          n       = power_off_all(n);
          n.seq   = pusq_pkg::ST_ACCOFF2;
          n.timer = '0;
        end else if (item.ignition_on) begin
          n.lv.remote = 1'b1;
          n.seq = n.app_started ? pusq_pkg::ST_SECURITY : pusq_pkg::ST_ON_DELAY;
        end
      end
      pusq_pkg::ST_ACCOFF2: begin
        if (n.timer >= cfg.opamp_off_wait) begin
          n.lv.opamp = 1'b0;
          if (!item.ignition_on) begin
            events[pusq_pkg::EV_SLEEP] = 1'b1;
          end
          n.seq = pusq_pkg::ST_STANDBY;
        end
      end
      pusq_pkg::ST_ERR_RESET: begin
        if (n.timer >= ErrTicks) begin
          n.timer = '0;
          n.seq   = pusq_pkg::ST_ON_START;
        end
      end
      default: begin
        // run and unused codes hold
      end
    endcase
  end

  assign st_next       = n;
  assign res.seq       = n.seq;
  assign res.reason    = n.reason;
  assign res.lv        = n.lv;
  assign res.dsp_pulse = dsp_pulse;
  assign res.events    = events;

endmodule

### src/power_up_down_sequencer_core.sv
// Top level of the power up/down sequencer: register port, input and result stages.
// Depends on pusq_pkg, pusq_step and power_up_down_sequencer_core_defines.svh.
//
//   channel | handshake                       | payload
//   --------+---------------------------------+--------------------------------------
//   in      | in_valid / in_stall             | msg_kind msg_reason ignition_on
//           |                                 | voltage_error sleep_active dsp_ready
//   out     | out_valid / out_stall           | power_state off_reason levels, pulses
//   cfg     | psel penable pwrite pready      | paddr pwdata prdata (8 x 16-bit regs)
//
// One tick beat is taken per cycle while in_stall is low; each beat gives one result
// beat (input register, then the step logic into the result register).
// The state update happens as a beat leaves the input register, so ticks chain
// back to back. rst is synchronous and returns the state, config and valid flags
// to their defaults. out_stall holds the result register; in_stall rises only when
// the input register is full and cannot move on.
`include "power_up_down_sequencer_core_defines.svh"

module power_up_down_sequencer_core #(
  parameter int ERR_RESET_TICKS = 125
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  msg_kind,
  input  logic [1:0]  msg_reason,
  input  logic        ignition_on,
  input  logic        voltage_error,
  input  logic        sleep_active,
  input  logic        dsp_ready,
  // result
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  power_state,
  output logic [1:0]  off_reason,
  output logic        mute,
  output logic        main_power,
  output logic        remote_enable,
  output logic        usb_enable,
  output logic        opamp_enable,
  output logic        amp_enable,
  output logic        host_reset_hold,
  output logic        periph_reset_hold,
  output logic        dsp_enable_pulse,
  output logic [3:0]  event_pulses
);

  pusq_pkg::cfg_t        cfg;
  pusq_pkg::core_state_t st;
  pusq_pkg::core_state_t st_next;
  pusq_pkg::item_t       s1_item;
  pusq_pkg::result_t     step_res;
  pusq_pkg::result_t     res;
  logic                  s1_valid;
  logic                  out_free;
  logic                  s1_adv;
  logic                  in_take;
  logic                  cfg_wr;
  logic [pusq_pkg::REG_IDX_W-1:0] reg_idx;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[pusq_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pusq_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        pusq_pkg::REG_START_WAIT:      cfg.start_wait        <= pwdata[15:0];
        pusq_pkg::REG_RESET_WAIT:      cfg.reset_wait        <= pwdata[15:0];
        pusq_pkg::REG_RECOVER_WAIT:    cfg.recover_wait      <= pwdata[15:0];
        pusq_pkg::REG_DSP_TIMEOUT:     cfg.dsp_timeout       <= pwdata[15:0];
        pusq_pkg::REG_CLOSE_WAIT:      cfg.close_screen_wait <= pwdata[15:0];
        pusq_pkg::REG_REMOTE_OFF_WAIT: cfg.remote_off_wait   <= pwdata[15:0];
        pusq_pkg::REG_ACCOFF_WAIT:     cfg.accoff_wait       <= pwdata[15:0];
        pusq_pkg::REG_OPAMP_OFF_WAIT:  cfg.opamp_off_wait    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pusq_pkg::REG_START_WAIT:      prdata = {16'h0, cfg.start_wait};
      pusq_pkg::REG_RESET_WAIT:      prdata = {16'h0, cfg.reset_wait};
      pusq_pkg::REG_RECOVER_WAIT:    prdata = {16'h0, cfg.recover_wait};
      pusq_pkg::REG_DSP_TIMEOUT:     prdata = {16'h0, cfg.dsp_timeout};
      pusq_pkg::REG_CLOSE_WAIT:      prdata = {16'h0, cfg.close_screen_wait};
      pusq_pkg::REG_REMOTE_OFF_WAIT: prdata = {16'h0, cfg.remote_off_wait};
      pusq_pkg::REG_ACCOFF_WAIT:     prdata = {16'h0, cfg.accoff_wait};
      pusq_pkg::REG_OPAMP_OFF_WAIT:  prdata = {16'h0, cfg.opamp_off_wait};
      default:                       prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= '{msg_kind:      msg_kind,
                   msg_reason:    msg_reason,
                   ignition_on:   ignition_on,
                   voltage_error: voltage_error,
                   sleep_active:  sleep_active,
                   dsp_ready:     dsp_ready};
    end
  end

  // ---------------- tick step ----------------
  pusq_step #(
    .ERR_RESET_TICKS(ERR_RESET_TICKS)
  ) u_step (
    .st      (st),
    .item    (s1_item),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= pusq_pkg::CORE_RESET;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= step_res;
    end
  end

  assign power_state       = 4'(res.seq);
  assign off_reason        = res.reason;
  assign mute              = res.lv.mute;
  assign main_power        = res.lv.main_pwr;
  assign remote_enable     = res.lv.remote;
  assign usb_enable        = res.lv.usb;
  assign opamp_enable      = res.lv.opamp;
  assign amp_enable        = res.lv.amp;
  assign host_reset_hold   = res.lv.host_rst;
  assign periph_reset_hold = res.lv.periph_rst;
  assign dsp_enable_pulse  = res.dsp_pulse;
  assign event_pulses      = res.events;

  // ---------------- checks ----------------
  `PUSQ_ASSERT_ALWAYS(a_rst_empty, rst |=> (!s1_valid && !out_valid), "stages not empty after reset")
  `PUSQ_ASSERT(a_stall_only_full, in_stall |-> s1_valid, "input stalled with empty input register")
  `PUSQ_ASSERT(a_adv_fills_out, s1_adv |=> out_valid, "advanced beat lost before result register")
  `PUSQ_ASSERT(a_dsp_pulse_state, (out_valid && dsp_enable_pulse) |-> (power_state == 4'(pusq_pkg::ST_SECURITY)), "DSP enable pulse outside security state")
  `PUSQ_ASSERT(a_app_ok_unmuted, (out_valid && event_pulses[pusq_pkg::EV_APP_OK]) |-> (!mute && power_state == 4'(pusq_pkg::ST_RUN)), "app start event without run and unmute")

endmodule
